>>> rtl/lwm_pkg.sv
// ----------------------------------------------------------------------------
// lwm_pkg: shared types, constants and helpers of the local weighted mean warp
// Holds the request and result structs, the sequencer state codes, the Q32.32
// constants and the saturating add, subtract and magnitude helpers.
// ----------------------------------------------------------------------------
package lwm_pkg;

	localparam int CONTROL_POINTS_DEF   = 64;
	localparam int MAX_REFINE_STEPS_DEF = 100;
	localparam int WORDS_PER_POINT      = 15;

	localparam logic [3:0] WORD_CX  = 4'd0;
	localparam logic [3:0] WORD_CY  = 4'd1;
	localparam logic [3:0] WORD_RAD = 4'd2;
	localparam logic [3:0] WORD_U0  = 4'd3;
	localparam logic [3:0] WORD_V0  = 4'd9;

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_XFORM = 1'b1;

	// Register index as seen on paddr[2].
	localparam logic REG_ACTIVE_POINTS = 1'b0;
	localparam logic [6:0] ACTIVE_POINTS_RST = 7'd64;

	localparam logic signed [63:0] Q_ONE         = 64'sh0000_0001_0000_0000;
	localparam logic signed [63:0] Q_TWO         = 64'sh0000_0002_0000_0000;
	localparam logic signed [63:0] Q_THREE       = 64'sh0000_0003_0000_0000;
	localparam logic signed [63:0] Q_HALF        = 64'sh0000_0000_8000_0000;
	localparam logic signed [63:0] Q_FOUR_FIFTHS = 64'sh0000_0000_CCCC_CCCD;
	localparam logic signed [63:0] Q_EPS         = 64'sh0000_0000_0000_10C7;
	localparam logic signed [63:0] Q_MAX         = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] Q_MIN         = 64'sh8000_0000_0000_0000;

	typedef struct packed {
		logic               func;
		logic               table_sel;
		logic [5:0]         entry;
		logic [3:0]         word_sel;
		logic signed [63:0] word_value;
		logic signed [63:0] point_x;
		logic signed [63:0] point_y;
		logic               use_inverse;
		logic               refine;
	} lwm_req_t;

	typedef struct packed {
		logic signed [63:0] out_x;
		logic signed [63:0] out_y;
		logic               covered;
	} lwm_rsp_t;

	// Operation request to a shared arithmetic unit.
	typedef struct packed {
		logic               go;
		logic signed [63:0] a;
		logic signed [63:0] b;
	} lwm_op_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_W_XY, ST_W_X2, ST_W_Y2, ST_W_PT, ST_W_RAD, ST_W_E0, ST_W_E1,
		ST_D_DX, ST_D_DY, ST_D_SQ, ST_W_R, ST_W_R2, ST_W_R3, ST_W_W3, ST_W_W2,
		ST_W_C0, ST_W_CRD, ST_W_CMUL, ST_W_ACC, ST_W_END, ST_W_DIVU, ST_W_DIVV,
		ST_W_RET, ST_R_LOOP, ST_R_MX, ST_R_MY, ST_R_CMP, ST_R_SHRINK, ST_R_K,
		ST_DONE
	} lwm_state_t;

	// Who called the warp walk.
	typedef enum logic [1:0] {WC_MAIN, WC_FIRST, WC_TRY} lwm_wctx_t;

	// Who called the distance sequence.
	typedef enum logic [1:0] {DC_WARP, DC_FIRST, DC_TRY} lwm_dctx_t;

	function automatic logic signed [63:0] sat_add(logic signed [63:0] a,
	                                               logic signed [63:0] b);
		logic signed [63:0] s;
		s = a + b;
		if (!a[63] && !b[63] && s[63]) return Q_MAX;
		if (a[63] && b[63] && !s[63]) return Q_MIN;
		return s;
	endfunction

	function automatic logic signed [63:0] sat_sub(logic signed [63:0] a,
	                                               logic signed [63:0] b);
		logic signed [63:0] s;
		s = a - b;
		if (!a[63] && b[63] && s[63]) return Q_MAX;
		if (a[63] && !b[63] && !s[63]) return Q_MIN;
		return s;
	endfunction

	function automatic logic [63:0] mag(logic signed [63:0] a);
		return a[63] ? 64'(-a) : 64'(a);
	endfunction

	// Signs a 96-bit magnitude and saturates it to the signed 64-bit range.
	function automatic logic signed [63:0] sat_mag(logic neg, logic [95:0] m);
		if (m[95:63] != '0) return neg ? Q_MIN : Q_MAX;
		return neg ? -$signed(m[63:0]) : $signed(m[63:0]);
	endfunction

endpackage

>>> rtl/lwm_mem.sv
// ----------------------------------------------------------------------------
// lwm_mem: coefficient table storage
// One write port and one read port with registered read data and a valid
// pulse in the cycle after each read.
// ----------------------------------------------------------------------------
module lwm_mem import lwm_pkg::*; #(
	parameter int DEPTH = 2 * CONTROL_POINTS_DEF * WORDS_PER_POINT,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic signed [63:0]   wdata,
	input  logic                 re,
	input  logic [AW-1:0]        raddr,
	output logic signed [63:0]   rdata,
	output logic                 rvld
);

	logic [63:0] mem_q [0:DEPTH-1];
	logic [63:0] rdata_q;
	logic        rvld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvld_q <= 1'b0;
		end else begin
			rvld_q <= re;
		end
	end

	assign rdata = $signed(rdata_q);
	assign rvld  = rvld_q;

endmodule

>>> rtl/lwm_mul.sv
// ----------------------------------------------------------------------------
// lwm_mul: shared Q32.32 multiplier
// Forms the 128-bit magnitude product from four 32x32 partial products, one
// per cycle, then shifts right by 32 and saturates.
// ----------------------------------------------------------------------------
module lwm_mul import lwm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  lwm_op_t            op,
	output logic               done,
	output logic signed [63:0] y
);

	logic [63:0]  ma_q, mb_q;
	logic         neg_q;
	logic [2:0]   ph_q;
	logic         run_q;
	logic         done_q;
	logic [63:0]  pp_q;
	logic [1:0]   idx_q;
	logic [127:0] acc_q;
	logic [31:0]  fa, fb;
	logic [127:0] addend;

	always_comb begin
		fa = ph_q[1] ? ma_q[63:32] : ma_q[31:0];
		fb = ph_q[0] ? mb_q[63:32] : mb_q[31:0];
		case (idx_q) inside
			2'd0:       addend = {64'b0, pp_q};
			2'd1, 2'd2: addend = {32'b0, pp_q, 32'b0};
			default:    addend = {pp_q, 64'b0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			ph_q   <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && (ph_q == 3'd4);
			if (op.go) begin
				run_q <= 1'b1;
				ph_q  <= '0;
			end else if (run_q) begin
				ph_q <= ph_q + 3'd1;
				if (ph_q == 3'd4) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op.go) begin
			ma_q  <= mag(op.a);
			mb_q  <= mag(op.b);
			neg_q <= op.a[63] ^ op.b[63];
			acc_q <= '0;
		end else if (run_q) begin
			if (ph_q != 3'd4) begin
				pp_q  <= fa * fb;
				idx_q <= ph_q[1:0];
			end
			if (ph_q != 3'd0) begin
				acc_q <= acc_q + addend;
			end
		end
	end

	assign done = done_q;
	assign y    = sat_mag(neg_q, acc_q[127:32]);

endmodule

>>> rtl/lwm_div.sv
// ----------------------------------------------------------------------------
// lwm_div: shared Q32.32 divider
// Restoring division of the magnitude shifted left by 32, one quotient bit
// per cycle, truncated toward zero and saturated.
// ----------------------------------------------------------------------------
module lwm_div import lwm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  lwm_op_t            op,
	output logic               done,
	output logic signed [63:0] y
);

	logic [63:0] ud_q;
	logic [95:0] num_q;
	logic [95:0] quo_q;
	logic [63:0] rem_q;
	logic [6:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic        neg_q;
	logic [64:0] r2;
	logic        ge;

	always_comb begin
		r2 = {rem_q, num_q[95]};
		ge = r2 >= {1'b0, ud_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && (cnt_q == 7'd95);
			if (op.go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd95) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op.go) begin
			ud_q  <= mag(op.b);
			num_q <= {mag(op.a), 32'b0};
			quo_q <= '0;
			rem_q <= '0;
			neg_q <= op.a[63] ^ op.b[63];
		end else if (run_q) begin
			rem_q <= ge ? 64'(r2 - {1'b0, ud_q}) : r2[63:0];
			quo_q <= {quo_q[94:0], ge};
			num_q <= {num_q[94:0], 1'b0};
		end
	end

	assign done = done_q;
	assign y    = sat_mag(neg_q, quo_q);

endmodule

>>> rtl/lwm_sqrt.sv
// ----------------------------------------------------------------------------
// lwm_sqrt: shared Q32.32 square root
// Digit-by-digit root of the value shifted left by 32, two radicand bits per
// cycle; a value at or below zero gives zero.
// ----------------------------------------------------------------------------
module lwm_sqrt import lwm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  lwm_op_t            op,
	output logic               done,
	output logic signed [63:0] y
);

	logic [95:0] x_q;
	logic [51:0] rem_q;
	logic [47:0] root_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [51:0] r4;
	logic [51:0] trial;
	logic        ge;

	always_comb begin
		r4    = {rem_q[49:0], x_q[95:94]};
		trial = {2'b00, root_q, 2'b01};
		ge    = r4 >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && (cnt_q == 6'd47);
			if (op.go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd47) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op.go) begin
			x_q    <= (!op.a[63] && op.a != '0) ? {op.a, 32'b0} : '0;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rem_q  <= ge ? r4 - trial : r4;
			root_q <= {root_q[46:0], ge};
			x_q    <= {x_q[93:0], 2'b00};
		end
	end

	assign done = done_q;
	assign y    = $signed({16'b0, root_q});

endmodule

>>> rtl/local_weighted_mean_warp_core.sv
// ----------------------------------------------------------------------------
// local_weighted_mean_warp_core: local weighted mean warp of a 2-D point
// Sequencer around one shared multiplier, divider and square root unit with
// a coefficient table memory and an APB register for the active point count.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A load request
// (func low) writes one table word in that cycle and leaves busy low, so the
// next request may follow at once; it produces no result. A transform
// request raises busy until its result has been delivered: out_x, out_y and
// covered appear on rsp for exactly one cycle with done high, and the
// receiver must take them then, since there is no way to hold them off.
// Each warp pass walks the active control points of one table through a single
// shared multiplier, a bit-serial divider and a two-bit-per-cycle square root,
// reading table words one at a time from the table memory. A pass ends with
// the two final divisions when any point covers; a skipped point ends before
// its coefficients are read. An inverse transform with refinement adds one
// pass and a distance for the first check and one pass plus a distance per
// try, up to MAX_REFINE_STEPS + 1 tries. The table has no reset and must be
// loaded before the entries in use are read. active_points must be written
// at byte address 0 only while the block is idle; the block itself does not
// enforce this. Values above CONTROL_POINTS act as CONTROL_POINTS.
// ----------------------------------------------------------------------------
module local_weighted_mean_warp_core import lwm_pkg::*; #(
	parameter int CONTROL_POINTS   = CONTROL_POINTS_DEF,
	parameter int MAX_REFINE_STEPS = MAX_REFINE_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Request channel.
	input  logic        start,
	output logic        busy,
	input  lwm_req_t    req,
	// Result channel.
	output logic        done,
	output lwm_rsp_t    rsp,
	// Register port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int PW    = $clog2(CONTROL_POINTS + 1);
	localparam int DEPTH = 2 * CONTROL_POINTS * WORDS_PER_POINT;
	localparam int AW    = $clog2(DEPTH);
	localparam int KW    = $clog2(MAX_REFINE_STEPS + 1);

	function automatic logic [AW-1:0] word_addr(int row, logic [3:0] w);
		return AW'(row * WORDS_PER_POINT + int'(w));
	endfunction

	lwm_state_t state_q, state_d;
	logic       iss_q;
	logic       done_q;
	logic [6:0] active_q;

	// Shared units.
	lwm_op_t            mul_op, div_op, sqrt_op;
	logic               mul_done, div_done, sqrt_done;
	logic signed [63:0] mul_y, div_y, sqrt_y;

	// Table memory.
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic               rd_go;
	logic [3:0]         rd_word;
	logic [AW-1:0]      rd_addr;
	logic signed [63:0] rd_data;
	logic               rd_vld;
	int                 rd_row;
	int                 ld_row;

	// Transform datapath.
	logic signed [63:0] px_q, py_q, wx_q, wy_q, xy_q, x2_q, y2_q;
	logic signed [63:0] un_q, vn_q, den_q, rad_q, ex_q, dx_q, dy_q, t1_q, dres_q;
	logic signed [63:0] r_q, r2_q, r3_q, w_q, s_q, coef_q, term;
	logic signed [63:0] wox_q, woy_q, ox_q, oy_q, tx_q, ty_q, cx_q, dist_q, mult_q;
	logic               inv_q, ref_q, tbl_q, wcov_q, rcov_q, cset_q;
	logic [2:0]         ci_q;
	logic [PW-1:0]      pt_q, nact_q;
	logic [KW-1:0]      k_q;
	lwm_wctx_t          wctx_q;
	lwm_dctx_t          dctx_q;
	lwm_rsp_t           rsp_q;
	logic               op_done;
	logic               issue;

	assign busy   = (state_q != ST_IDLE);
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_ACTIVE_POINTS) ? {25'b0, active_q} : 32'b0;

	// A load goes straight into the table in the cycle it is accepted.
	assign ld_row    = req.table_sel ? CONTROL_POINTS + int'(req.entry) : int'(req.entry);
	assign mem_we    = start && !busy && (req.func == FUNC_LOAD)
	                   && (int'(req.entry) < CONTROL_POINTS)
	                   && (int'(req.word_sel) < WORDS_PER_POINT);
	assign mem_waddr = word_addr(ld_row, req.word_sel);

	assign rd_row  = tbl_q ? CONTROL_POINTS + int'(pt_q) : int'(pt_q);
	assign rd_addr = word_addr(rd_row, rd_word);

	lwm_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (req.word_value),
		.re     (rd_go),
		.raddr  (rd_addr),
		.rdata  (rd_data),
		.rvld   (rd_vld)
	);

	lwm_mul u_mul (.clk(clk), .arst_n(arst_n), .op(mul_op), .done(mul_done), .y(mul_y));
	lwm_div u_div (.clk(clk), .arst_n(arst_n), .op(div_op), .done(div_done), .y(div_y));
	lwm_sqrt u_sqrt (.clk(clk), .arst_n(arst_n), .op(sqrt_op), .done(sqrt_done),
		.y(sqrt_y));

	// Only one unit is ever in flight, so any completion ends the current step.
	assign op_done = mul_done | div_done | sqrt_done | rd_vld;
	assign issue   = mul_op.go | div_op.go | sqrt_op.go | rd_go;

	// Polynomial term for coefficient index one through five.
	always_comb begin
		case (ci_q)
			3'd1:    term = wx_q;
			3'd2:    term = wy_q;
			3'd3:    term = xy_q;
			3'd4:    term = x2_q;
			default: term = y2_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			iss_q    <= 1'b0;
			done_q   <= 1'b0;
			active_q <= ACTIVE_POINTS_RST;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_DONE);
			if (issue) begin
				iss_q <= 1'b1;
			end else if (op_done) begin
				iss_q <= 1'b0;
			end
			if (psel && penable && pwrite && pready && (paddr[2] == REG_ACTIVE_POINTS)) begin
				active_q <= pwdata[6:0];
			end
		end
	end

	// Next state and unit requests. Each arithmetic or memory step issues its
	// request once and then waits for the completion pulse.
	always_comb begin
		state_d = state_q;
		mul_op  = '0;
		div_op  = '0;
		sqrt_op = '0;
		rd_go   = 1'b0;
		rd_word = WORD_RAD;
		unique case (state_q)
			ST_IDLE: begin
				if (start && req.func == FUNC_XFORM) state_d = ST_W_XY;
			end
			ST_W_XY: begin
				mul_op = '{go: !iss_q, a: wx_q, b: wy_q};
				if (mul_done) state_d = ST_W_X2;
			end
			ST_W_X2: begin
				mul_op = '{go: !iss_q, a: wx_q, b: wx_q};
				if (mul_done) state_d = ST_W_Y2;
			end
			ST_W_Y2: begin
				mul_op = '{go: !iss_q, a: wy_q, b: wy_q};
				if (mul_done) state_d = ST_W_PT;
			end
			ST_W_PT: begin
				state_d = (pt_q == nact_q) ? ST_W_END : ST_W_RAD;
			end
			ST_W_RAD: begin
				rd_go   = !iss_q;
				rd_word = WORD_RAD;
				if (rd_vld) state_d = (rd_data <= 0) ? ST_W_PT : ST_W_E0;
			end
			ST_W_E0: begin
				rd_go   = !iss_q;
				rd_word = WORD_CX;
				if (rd_vld) state_d = ST_W_E1;
			end
			ST_W_E1: begin
				rd_go   = !iss_q;
				rd_word = WORD_CY;
				if (rd_vld) state_d = ST_D_DX;
			end
			ST_D_DX: begin
				mul_op = '{go: !iss_q, a: dx_q, b: dx_q};
				if (mul_done) state_d = ST_D_DY;
			end
			ST_D_DY: begin
				mul_op = '{go: !iss_q, a: dy_q, b: dy_q};
				if (mul_done) state_d = ST_D_SQ;
			end
			ST_D_SQ: begin
				sqrt_op = '{go: !iss_q, a: t1_q, b: '0};
				if (sqrt_done) begin
					unique case (dctx_q)
						DC_WARP:  state_d = ST_W_R;
						DC_FIRST: state_d = ST_R_LOOP;
						DC_TRY:   state_d = ST_R_CMP;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_W_R: begin
				div_op = '{go: !iss_q, a: dres_q, b: rad_q};
				if (div_done) state_d = (div_y >= Q_ONE) ? ST_W_PT : ST_W_R2;
			end
			ST_W_R2: begin
				mul_op = '{go: !iss_q, a: r_q, b: r_q};
				if (mul_done) state_d = ST_W_R3;
			end
			ST_W_R3: begin
				mul_op = '{go: !iss_q, a: r_q, b: r2_q};
				if (mul_done) state_d = ST_W_W3;
			end
			ST_W_W3: begin
				mul_op = '{go: !iss_q, a: Q_THREE, b: r2_q};
				if (mul_done) state_d = ST_W_W2;
			end
			ST_W_W2: begin
				mul_op = '{go: !iss_q, a: Q_TWO, b: r3_q};
				if (mul_done) state_d = ST_W_C0;
			end
			ST_W_C0: begin
				rd_go   = !iss_q;
				rd_word = cset_q ? WORD_V0 : WORD_U0;
				if (rd_vld) state_d = ST_W_CRD;
			end
			ST_W_CRD: begin
				rd_go   = !iss_q;
				rd_word = (cset_q ? WORD_V0 : WORD_U0) + {1'b0, ci_q};
				if (rd_vld) state_d = ST_W_CMUL;
			end
			ST_W_CMUL: begin
				mul_op = '{go: !iss_q, a: coef_q, b: term};
				if (mul_done) state_d = (ci_q == 3'd5) ? ST_W_ACC : ST_W_CRD;
			end
			ST_W_ACC: begin
				mul_op = '{go: !iss_q, a: w_q, b: s_q};
				if (mul_done) state_d = cset_q ? ST_W_PT : ST_W_C0;
			end
			ST_W_END: begin
				state_d = (den_q == '0) ? ST_W_RET : ST_W_DIVU;
			end
			ST_W_DIVU: begin
				div_op = '{go: !iss_q, a: un_q, b: den_q};
				if (div_done) state_d = ST_W_DIVV;
			end
			ST_W_DIVV: begin
				div_op = '{go: !iss_q, a: vn_q, b: den_q};
				if (div_done) state_d = ST_W_RET;
			end
			ST_W_RET: begin
				unique case (wctx_q)
					WC_MAIN:  state_d = (wcov_q && inv_q && ref_q) ? ST_W_XY : ST_DONE;
					WC_FIRST: state_d = wcov_q ? ST_D_DX : ST_DONE;
					WC_TRY:   state_d = wcov_q ? ST_D_DX : ST_DONE;
					default:  state_d = ST_IDLE;
				endcase
			end
			ST_R_LOOP: begin
				state_d = (dist_q <= Q_EPS) ? ST_DONE : ST_R_MX;
			end
			ST_R_MX: begin
				mul_op = '{go: !iss_q, a: mult_q, b: sat_sub(px_q, tx_q)};
				if (mul_done) state_d = ST_R_MY;
			end
			ST_R_MY: begin
				mul_op = '{go: !iss_q, a: mult_q, b: sat_sub(py_q, ty_q)};
				if (mul_done) state_d = ST_W_XY;
			end
			ST_R_CMP: begin
				state_d = (dres_q < dist_q) ? ST_R_K : ST_R_SHRINK;
			end
			ST_R_SHRINK: begin
				mul_op = '{go: !iss_q, a: mult_q, b: Q_FOUR_FIFTHS};
				if (mul_done) state_d = ST_R_K;
			end
			ST_R_K: begin
				state_d = (int'(k_q) >= MAX_REFINE_STEPS) ? ST_DONE : ST_R_LOOP;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Datapath registers, updated as each step completes.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start && req.func == FUNC_XFORM) begin
					px_q   <= req.point_x;
					py_q   <= req.point_y;
					wx_q   <= req.point_x;
					wy_q   <= req.point_y;
					tbl_q  <= req.use_inverse;
					inv_q  <= req.use_inverse;
					ref_q  <= req.refine;
					wctx_q <= WC_MAIN;
					nact_q <= (int'(active_q) > CONTROL_POINTS) ? PW'(CONTROL_POINTS)
					                                            : PW'(active_q);
				end
			end
			ST_W_XY: if (mul_done) xy_q <= mul_y;
			ST_W_X2: if (mul_done) x2_q <= mul_y;
			ST_W_Y2: begin
				if (mul_done) begin
					y2_q  <= mul_y;
					un_q  <= '0;
					vn_q  <= '0;
					den_q <= '0;
					pt_q  <= '0;
				end
			end
			ST_W_RAD: begin
				if (rd_vld) begin
					if (rd_data <= 0) pt_q <= pt_q + PW'(1);
					else rad_q <= rd_data;
				end
			end
			ST_W_E0: if (rd_vld) ex_q <= rd_data;
			ST_W_E1: begin
				if (rd_vld) begin
					dx_q   <= sat_sub(wx_q, ex_q);
					dy_q   <= sat_sub(wy_q, rd_data);
					dctx_q <= DC_WARP;
				end
			end
			ST_D_DX: if (mul_done) t1_q <= mul_y;
			ST_D_DY: if (mul_done) t1_q <= sat_add(t1_q, mul_y);
			ST_D_SQ: begin
				if (sqrt_done) begin
					dres_q <= sqrt_y;
					if (dctx_q == DC_FIRST) begin
						dist_q <= sqrt_y;
						mult_q <= Q_HALF;
						k_q    <= '0;
					end
				end
			end
			ST_W_R: begin
				if (div_done) begin
					r_q <= div_y;
					if (div_y >= Q_ONE) pt_q <= pt_q + PW'(1);
				end
			end
			ST_W_R2: if (mul_done) r2_q <= mul_y;
			ST_W_R3: if (mul_done) r3_q <= mul_y;
			ST_W_W3: if (mul_done) w_q <= sat_sub(Q_ONE, mul_y);
			ST_W_W2: begin
				if (mul_done) begin
					w_q    <= sat_add(w_q, mul_y);
					cset_q <= 1'b0;
				end
			end
			ST_W_C0: begin
				if (rd_vld) begin
					s_q  <= rd_data;
					ci_q <= 3'd1;
				end
			end
			ST_W_CRD: if (rd_vld) coef_q <= rd_data;
			ST_W_CMUL: begin
				if (mul_done) begin
					s_q  <= sat_add(s_q, mul_y);
					ci_q <= ci_q + 3'd1;
				end
			end
			ST_W_ACC: begin
				if (mul_done) begin
					if (!cset_q) begin
						un_q   <= sat_add(un_q, mul_y);
						cset_q <= 1'b1;
					end else begin
						vn_q  <= sat_add(vn_q, mul_y);
						den_q <= sat_add(den_q, w_q);
						pt_q  <= pt_q + PW'(1);
					end
				end
			end
			ST_W_END: begin
				if (den_q == '0) begin
					wcov_q <= 1'b0;
					wox_q  <= wx_q;
					woy_q  <= wy_q;
				end
			end
			ST_W_DIVU: if (div_done) wox_q <= div_y;
			ST_W_DIVV: begin
				if (div_done) begin
					woy_q  <= div_y;
					wcov_q <= 1'b1;
				end
			end
			ST_W_RET: begin
				if (wctx_q == WC_MAIN) begin
					ox_q   <= wox_q;
					oy_q   <= woy_q;
					rcov_q <= wcov_q;
					if (wcov_q && inv_q && ref_q) begin
						// Check the inverse result through the forward table.
						wx_q   <= wox_q;
						wy_q   <= woy_q;
						tbl_q  <= 1'b0;
						wctx_q <= WC_FIRST;
					end
				end else begin
					tx_q   <= wox_q;
					ty_q   <= woy_q;
					dx_q   <= sat_sub(px_q, wox_q);
					dy_q   <= sat_sub(py_q, woy_q);
					dctx_q <= (wctx_q == WC_FIRST) ? DC_FIRST : DC_TRY;
				end
			end
			ST_R_MX: if (mul_done) cx_q <= sat_add(ox_q, mul_y);
			ST_R_MY: begin
				if (mul_done) begin
					wx_q   <= cx_q;
					wy_q   <= sat_add(oy_q, mul_y);
					tbl_q  <= 1'b0;
					wctx_q <= WC_TRY;
				end
			end
			ST_R_CMP: begin
				// A try that lowers the error is kept; the try point is still
				// held in wx_q and wy_q.
				if (dres_q < dist_q) begin
					dist_q <= dres_q;
					ox_q   <= wx_q;
					oy_q   <= wy_q;
				end
			end
			ST_R_SHRINK: if (mul_done) mult_q <= mul_y;
			ST_R_K: k_q <= k_q + KW'(1);
			ST_DONE: begin
				rsp_q.out_x   <= ox_q;
				rsp_q.out_y   <= oy_q;
				rsp_q.covered <= rcov_q;
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	// A unit completes only for a request that this sequencer issued.
	a_done_issued: assert property (@(posedge clk) disable iff (!arst_n)
		op_done |-> iss_q)
		else $error("unit completion without an outstanding request");

	// At most one unit or memory read is started in a cycle.
	a_one_issue: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({mul_op.go, div_op.go, sqrt_op.go, rd_go}))
		else $error("more than one unit started at once");

	// No new request while another one is still outstanding.
	a_no_reissue: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> !iss_q)
		else $error("unit started while a request is outstanding");

	// Table writes only happen between transforms.
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_IDLE))
		else $error("table written during a transform");

	// A result is a single-cycle strobe that leaves the block idle.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == ST_IDLE) && $past(state_q) == ST_DONE)
		else $error("result strobe outside the delivery step");

endmodule
